>>> rtl/core/sfr_pkg.sv
`timescale 1ns / 1ps

package sfr_pkg;

  // Payload storage
  localparam int MAX_PAYLOAD = 32;
  localparam int PAY_AW      = $clog2(MAX_PAYLOAD);
  localparam int PS_W        = 6;

  // Fletcher sums are kept mod 255
  localparam logic [8:0] FLETCHER_MOD = 9'd255;

  // Configuration port
  localparam int APB_AW = 4;
  localparam logic [APB_AW-1:0] ADDR_PAYLOAD_SIZE = 4'h0;
  localparam logic [APB_AW-1:0] ADDR_SYNC_FIRST   = 4'h4;
  localparam logic [APB_AW-1:0] ADDR_SYNC_SECOND  = 4'h8;

  // Result item width: payload, event, link state, five counters
  localparam int TDATA_W = 176;

  typedef enum logic [2:0] {
    EV_FRAME_BYTE   = 3'd0,
    EV_LOST_HUNTING = 3'd1,
    EV_HEADER_BYTE  = 3'd2,
    EV_FRAME_OK     = 3'd3,
    EV_CHECKSUM_BAD = 3'd4,
    EV_SYNC_DROP    = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    LINK_IDLE      = 2'd0,
    LINK_SYNCING   = 2'd1,
    LINK_RECEIVING = 2'd2
  } link_t;

  typedef struct packed {
    logic [PS_W-1:0] payload_size;
    logic [7:0]      sync_first;
    logic [7:0]      sync_second;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic take_in;    // latch the incoming byte
    logic step;       // apply the byte to the frame state
    logic rd;         // read next stored payload byte
    logic load_pay;   // put a payload item in the output register
    logic load_stat;  // put the closing status item in the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic good_frame;
    logic drain_done;
    logic slot_free;
  } stat_t;

endpackage

>>> rtl/core/sfr_ram.sv
`timescale 1ns / 1ps

module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/sfr_ctrl.sv
`timescale 1ns / 1ps

module sfr_ctrl
  import sfr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  output cmd_t  cmd,
  input  stat_t stat
);

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_CALC      = 5'b00010,
    ST_DRAIN_RD  = 5'b00100,
    ST_DRAIN_OUT = 5'b01000,
    ST_EMIT      = 5'b10000
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == ST_IDLE);

  // Commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.take_in = 1'b1;
          state_next  = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.step   = 1'b1;
        state_next = stat.good_frame ? ST_DRAIN_RD : ST_EMIT;
      end
      ST_DRAIN_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_DRAIN_OUT;
      end
      ST_DRAIN_OUT: begin
        if (stat.slot_free) begin
          cmd.load_pay = 1'b1;
          state_next   = stat.drain_done ? ST_EMIT : ST_DRAIN_RD;
        end
      end
      ST_EMIT: begin
        if (stat.slot_free) begin
          cmd.load_stat = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/core/sfr_dp.sv
`timescale 1ns / 1ps

module sfr_dp
  import sfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic [7:0]         s_tdata,
  input  cmd_t               cmd,
  output stat_t              stat,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,
  output logic               m_tlast,
  output logic               m_tuser
);

  // Frame state
  logic [7:0]      rx;
  logic [PS_W-1:0] pos, pos_next;
  logic            locked, locked_next;
  logic [7:0]      sum_lo, sum_lo_next, sum_hi, sum_hi_next;
  logic [7:0]      ck_lo, ck_lo_next;
  link_t           link, link_next;
  event_t          ev, ev_next;
  logic [31:0]     n_bytes, n_good, n_fail, n_drop, n_lost;
  logic [31:0]     n_good_next, n_fail_next, n_drop_next, n_lost_next;
  logic [PS_W-1:0] idx;

  // Output register
  logic            out_valid, out_kind, out_last;
  logic [7:0]      out_byte;
  event_t          out_ev;
  link_t           out_link;
  logic [31:0]     o_bytes, o_good, o_fail, o_drop, o_lost;

  // Effective payload size and frame length
  logic [PS_W-1:0] ps;
  logic [PS_W:0]   flen, pos_inc;
  logic [PS_W-1:0] pos_m2;

  always_comb begin
    if (cfg.payload_size == '0) begin
      ps = PS_W'(1);
    end else if (cfg.payload_size > PS_W'(MAX_PAYLOAD)) begin
      ps = PS_W'(MAX_PAYLOAD);
    end else begin
      ps = cfg.payload_size;
    end
  end

  assign flen    = {1'b0, ps} + (PS_W+1)'(4);
  assign pos_inc = {1'b0, pos} + (PS_W+1)'(1);
  assign pos_m2  = pos - PS_W'(2);

  // Fletcher fold of the current byte, and the restart form from zero sums
  logic [8:0] lo_sum, hi_sum;
  logic [7:0] fold_lo, fold_hi, rs_lo;

  assign lo_sum  = {1'b0, sum_lo} + {1'b0, rx};
  assign fold_lo = (lo_sum >= FLETCHER_MOD) ? 8'(lo_sum - FLETCHER_MOD) : lo_sum[7:0];
  assign hi_sum  = {1'b0, sum_hi} + {1'b0, fold_lo};
  assign fold_hi = (hi_sum >= FLETCHER_MOD) ? 8'(hi_sum - FLETCHER_MOD) : hi_sum[7:0];
  assign rs_lo   = (rx == 8'hFF) ? 8'h00 : rx;

  // Frame state update for one byte
  logic ram_we, good;

  always_comb begin
    pos_next    = pos;
    locked_next = locked;
    sum_lo_next = sum_lo;
    sum_hi_next = sum_hi;
    ck_lo_next  = ck_lo;
    link_next   = link;
    ev_next     = ev;
    n_good_next = n_good;
    n_fail_next = n_fail;
    n_drop_next = n_drop;
    n_lost_next = n_lost;
    ram_we      = 1'b0;
    good        = 1'b0;
    if ({1'b0, pos} >= flen) begin
      // position overran the frame: drop and hunt again
      n_drop_next = n_drop + 32'd1;
      locked_next = 1'b0;
      pos_next    = '0;
      ev_next     = EV_SYNC_DROP;
    end else if (!locked) begin
      link_next = LINK_SYNCING;
      ev_next   = EV_HEADER_BYTE;
      if (pos == PS_W'(1) && rx == cfg.sync_second) begin
        sum_lo_next = fold_lo;
        sum_hi_next = fold_hi;
        pos_next    = PS_W'(2);
        locked_next = 1'b1;
      end else if (rx == cfg.sync_first) begin
        sum_lo_next = rs_lo;
        sum_hi_next = rs_lo;
        pos_next    = PS_W'(1);
      end else begin
        n_lost_next = n_lost + 32'd1;
        pos_next    = '0;
        ev_next     = EV_LOST_HUNTING;
      end
    end else begin
      link_next = LINK_RECEIVING;
      ev_next   = EV_FRAME_BYTE;
      if (pos >= PS_W'(2) && pos_m2 < ps) begin
        ram_we      = 1'b1;
        sum_lo_next = fold_lo;
        sum_hi_next = fold_hi;
      end else if ({1'b0, pos} == {1'b0, ps} + (PS_W+1)'(2)) begin
        ck_lo_next = rx;
      end
      pos_next = pos_inc[PS_W-1:0];
      if (pos_inc >= flen) begin
        pos_next    = '0;
        locked_next = 1'b0;
        if (sum_hi == rx && sum_lo == ck_lo) begin
          good        = 1'b1;
          n_good_next = n_good + 32'd1;
          ev_next     = EV_FRAME_OK;
        end else begin
          n_fail_next = n_fail + 32'd1;
          ev_next     = EV_CHECKSUM_BAD;
        end
      end
    end
  end

  // Payload store
  logic [7:0] rd_byte;

  sfr_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.step && ram_we),
    .waddr (pos_m2[PAY_AW-1:0]),
    .wdata (rx),
    .re    (cmd.rd),
    .raddr (idx[PAY_AW-1:0]),
    .rdata (rd_byte)
  );

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      locked  <= 1'b0;
      sum_lo  <= '0;
      sum_hi  <= '0;
      ck_lo   <= '0;
      link    <= LINK_IDLE;
      ev      <= EV_FRAME_BYTE;
      n_bytes <= '0;
      n_good  <= '0;
      n_fail  <= '0;
      n_drop  <= '0;
      n_lost  <= '0;
      idx     <= '0;
    end else begin
      if (cmd.step) begin
        pos     <= pos_next;
        locked  <= locked_next;
        sum_lo  <= sum_lo_next;
        sum_hi  <= sum_hi_next;
        ck_lo   <= ck_lo_next;
        link    <= link_next;
        ev      <= ev_next;
        n_bytes <= n_bytes + 32'd1;
        n_good  <= n_good_next;
        n_fail  <= n_fail_next;
        n_drop  <= n_drop_next;
        n_lost  <= n_lost_next;
        idx     <= '0;
      end else if (cmd.rd) begin
        idx <= idx + PS_W'(1);
      end
    end
  end

  // Input byte latch
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      rx <= s_tdata;
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_pay || cmd.load_stat) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: payload, snapshot of counters at load
  always_ff @(posedge clk) begin
    if (cmd.load_pay || cmd.load_stat) begin
      out_kind <= cmd.load_pay;
      out_byte <= cmd.load_pay ? rd_byte : 8'h00;
      out_last <= cmd.load_stat;
      out_ev   <= ev;
      out_link <= link;
      o_bytes  <= n_bytes;
      o_good   <= n_good;
      o_fail   <= n_fail;
      o_drop   <= n_drop;
      o_lost   <= n_lost;
    end
  end

  assign stat.good_frame = good;
  assign stat.drain_done = (idx == ps);
  assign stat.slot_free  = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tuser  = out_kind;
  assign m_tdata  = {3'b000, o_lost, o_drop, o_fail, o_good, o_bytes,
                     out_link, out_ev, out_byte};

endmodule

>>> rtl/core/sync_framed_fletcher_receiver.sv
`timescale 1ns / 1ps

// Sync-framed receiver with Fletcher-16 check. Link bytes enter on the slave
// stream; each is latched, applied in one update of the frame state and then
// loaded into the output register, and yields one status item. A byte that
// completes a frame with a correct little-endian Fletcher-16 (mod 255, over
// both sync bytes and the payload) first yields the stored payload as items
// of kind 1, each first read from the registered payload RAM and then loaded,
// and then the status item, which alone carries tlast. No new byte is taken
// until the last item of a byte is loaded, which a master-side stall delays.
// Counters wrap at 32 bits and are captured with each item. Registers on the
// APB port: payload_size at 0x0, sync_first at 0x4, sync_second at 0x8;
// write them only while no item is in flight.
module sync_framed_fletcher_receiver
  import sfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // received bytes
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] rx_byte
  // result items
  output logic               m_tvalid,
  input  logic               m_tready,
  // [7:0] payload_byte, [10:8] event_code, [12:11] link_state,
  // [44:13] bytes_seen, [76:45] frames_good, [108:77] checksum_failures,
  // [140:109] sync_drops, [172:141] bytes_lost_hunting, [175:173] zero
  output logic [TDATA_W-1:0] m_tdata,
  output logic               m_tlast,   // run_last
  output logic               m_tuser    // [0] item_kind
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.payload_size <= PS_W'(32);
      cfg.sync_first   <= 8'd170;
      cfg.sync_second  <= 8'd85;
    end else if (wr_en) begin
      if (paddr == ADDR_PAYLOAD_SIZE) begin
        cfg.payload_size <= pwdata[PS_W-1:0];
      end
      if (paddr == ADDR_SYNC_FIRST) begin
        cfg.sync_first <= pwdata[7:0];
      end
      if (paddr == ADDR_SYNC_SECOND) begin
        cfg.sync_second <= pwdata[7:0];
      end
    end
  end

  // Register read-back
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_PAYLOAD_SIZE) begin
      prdata = {{(32-PS_W){1'b0}}, cfg.payload_size};
    end else if (paddr == ADDR_SYNC_FIRST) begin
      prdata = {24'd0, cfg.sync_first};
    end else if (paddr == ADDR_SYNC_SECOND) begin
      prdata = {24'd0, cfg.sync_second};
    end
  end

  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  sfr_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

>>> bench/tb_sync_framed_fletcher_receiver.sv
`timescale 1ns / 1ps

module tb_sync_framed_fletcher_receiver;
  import sfr_pkg::*;

  // Address with no register behind it; writes there are dropped
  localparam logic [APB_AW-1:0] ADDR_UNUSED = 4'hC;
  localparam int RANDOM_BYTES = 450;
  localparam int SETTLE_CYCLES = 16;

  typedef struct {
    logic       kind;
    logic [7:0] pay;
    logic       last;
    event_t     ev;
    link_t      link;
    logic [31:0] n_bytes;
    logic [31:0] n_good;
    logic [31:0] n_bad_csum;
    logic [31:0] n_drops;
    logic [31:0] n_lost;
  } deframed_t;

  typedef enum {ROW_RX, ROW_CSUM_LO, ROW_CSUM_HI, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [7:0]        value;
    logic [APB_AW-1:0] addr;
    bit                fixed;
    event_t            ev;
    link_t             link;
  } dir_row_t;

  logic clk;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic m_tlast;
  logic m_tuser;

  sync_framed_fletcher_receiver i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // Mirror of the deframer state
  logic [PS_W-1:0] cfg_ps = 6'd32;
  logic [7:0] cfg_sync1 = 8'd170;
  logic [7:0] cfg_sync2 = 8'd85;
  logic [7:0] pay_store [MAX_PAYLOAD];
  bit pay_written [MAX_PAYLOAD];
  int rx_pos = 0;
  bit hdr_locked = 1'b0;
  logic [7:0] sum_lo = '0;
  logic [7:0] sum_hi = '0;
  logic [7:0] csum_lo_byte = '0;
  link_t link_now = LINK_IDLE;
  logic [31:0] n_bytes = '0;
  logic [31:0] n_good = '0;
  logic [31:0] n_bad_csum = '0;
  logic [31:0] n_drops = '0;
  logic [31:0] n_lost = '0;

  deframed_t deframed_q [$];
  int fail_count = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  dir_row_t directed_rows [31] = '{
    // hunting at reset settings
    '{ROW_RX, 8'h00, ADDR_UNUSED, 1'b1, EV_LOST_HUNTING, LINK_SYNCING},
    '{ROW_RX, 8'hFF, ADDR_UNUSED, 1'b1, EV_LOST_HUNTING, LINK_SYNCING},
    '{ROW_REG, 8'd1, ADDR_PAYLOAD_SIZE, 1'b0, EV_FRAME_BYTE, LINK_IDLE},
    // good one-byte frame with the first sync repeated
    '{ROW_RX, 8'hAA, ADDR_UNUSED, 1'b1, EV_HEADER_BYTE, LINK_SYNCING},
    '{ROW_RX, 8'hAA, ADDR_UNUSED, 1'b1, EV_HEADER_BYTE, LINK_SYNCING},
    '{ROW_RX, 8'h55, ADDR_UNUSED, 1'b1, EV_HEADER_BYTE, LINK_SYNCING},
    '{ROW_RX, 8'hFF, ADDR_UNUSED, 1'b1, EV_FRAME_BYTE, LINK_RECEIVING},
    '{ROW_CSUM_LO, 8'h00, ADDR_UNUSED, 1'b1, EV_FRAME_BYTE, LINK_RECEIVING},
    '{ROW_CSUM_HI, 8'h00, ADDR_UNUSED, 1'b0, EV_FRAME_BYTE, LINK_IDLE},
    // bad checksum
    '{ROW_RX, 8'hAA, ADDR_UNUSED, 1'b1, EV_HEADER_BYTE, LINK_SYNCING},
    '{ROW_RX, 8'h55, ADDR_UNUSED, 1'b1, EV_HEADER_BYTE, LINK_SYNCING},
    '{ROW_RX, 8'h00, ADDR_UNUSED, 1'b1, EV_FRAME_BYTE, LINK_RECEIVING},
    '{ROW_RX, 8'h00, ADDR_UNUSED, 1'b1, EV_FRAME_BYTE, LINK_RECEIVING},
    '{ROW_RX, 8'h00, ADDR_UNUSED, 1'b1, EV_CHECKSUM_BAD, LINK_RECEIVING},
    // oversize payload, extreme sync values, write to no register
    '{ROW_REG, 8'd63, ADDR_PAYLOAD_SIZE, 1'b0, EV_FRAME_BYTE, LINK_IDLE},
    '{ROW_REG, 8'h00, ADDR_SYNC_FIRST, 1'b0, EV_FRAME_BYTE, LINK_IDLE},
    '{ROW_REG, 8'hFF, ADDR_SYNC_SECOND, 1'b0, EV_FRAME_BYTE, LINK_IDLE},
    '{ROW_REG, 8'h5A, ADDR_UNUSED, 1'b0, EV_FRAME_BYTE, LINK_IDLE},
    '{ROW_RX, 8'h00, ADDR_UNUSED, 1'b1, EV_HEADER_BYTE, LINK_SYNCING},
    '{ROW_RX, 8'hFF, ADDR_UNUSED, 1'b1, EV_HEADER_BYTE, LINK_SYNCING},
    '{ROW_RX, 8'h01, ADDR_UNUSED, 1'b1, EV_FRAME_BYTE, LINK_RECEIVING},
    '{ROW_RX, 8'h80, ADDR_UNUSED, 1'b1, EV_FRAME_BYTE, LINK_RECEIVING},
    '{ROW_RX, 8'h7F, ADDR_UNUSED, 1'b1, EV_FRAME_BYTE, LINK_RECEIVING},
    // shrink the frame under the current position: sync drop
    '{ROW_REG, 8'd0, ADDR_PAYLOAD_SIZE, 1'b0, EV_FRAME_BYTE, LINK_IDLE},
    '{ROW_RX, 8'h12, ADDR_UNUSED, 1'b1, EV_SYNC_DROP, LINK_RECEIVING},
    // zero payload size acts as one
    '{ROW_RX, 8'h00, ADDR_UNUSED, 1'b1, EV_HEADER_BYTE, LINK_SYNCING},
    '{ROW_RX, 8'h00, ADDR_UNUSED, 1'b1, EV_HEADER_BYTE, LINK_SYNCING},
    '{ROW_RX, 8'hFF, ADDR_UNUSED, 1'b1, EV_HEADER_BYTE, LINK_SYNCING},
    '{ROW_RX, 8'h5A, ADDR_UNUSED, 1'b1, EV_FRAME_BYTE, LINK_RECEIVING},
    '{ROW_CSUM_LO, 8'h00, ADDR_UNUSED, 1'b1, EV_FRAME_BYTE, LINK_RECEIVING},
    '{ROW_CSUM_HI, 8'h00, ADDR_UNUSED, 1'b0, EV_FRAME_BYTE, LINK_IDLE}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int eff_of(input logic [PS_W-1:0] ps);
    if (ps == 0) return 1;
    if (int'(ps) > MAX_PAYLOAD) return MAX_PAYLOAD;
    return int'(ps);
  endfunction

  // Every entry below n written at least once since reset
  function automatic bit store_filled(input int n);
    for (int i = 0; i < n; i++)
      if (!pay_written[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void fold_sum(input logic [7:0] b);
    sum_lo = 8'((int'(sum_lo) + int'(b)) % int'(FLETCHER_MOD));
    sum_hi = 8'((int'(sum_hi) + int'(sum_lo)) % int'(FLETCHER_MOD));
  endfunction

  function automatic void queue_item(input logic kind, input logic [7:0] pay,
                                     input logic last, input event_t ev);
    deframed_t r;
    r.kind = kind;
    r.pay = pay;
    r.last = last;
    r.ev = ev;
    r.link = link_now;
    r.n_bytes = n_bytes;
    r.n_good = n_good;
    r.n_bad_csum = n_bad_csum;
    r.n_drops = n_drops;
    r.n_lost = n_lost;
    deframed_q.push_back(r);
  endfunction

  // Apply one received byte and queue what it should produce
  function automatic void deframe_byte(input logic [7:0] b);
    int ps;
    int flen;
    ps = eff_of(cfg_ps);
    flen = ps + 4;
    n_bytes++;
    if (rx_pos >= flen) begin
      n_drops++;
      hdr_locked = 1'b0;
      rx_pos = 0;
      queue_item(1'b0, 8'h00, 1'b1, EV_SYNC_DROP);
      return;
    end
    if (!hdr_locked) begin
      link_now = LINK_SYNCING;
      if (rx_pos == 1 && b == cfg_sync2) begin
        fold_sum(b);
        rx_pos = 2;
        hdr_locked = 1'b1;
        queue_item(1'b0, 8'h00, 1'b1, EV_HEADER_BYTE);
      end else if (b == cfg_sync1) begin
        sum_lo = '0;
        sum_hi = '0;
        fold_sum(b);
        rx_pos = 1;
        queue_item(1'b0, 8'h00, 1'b1, EV_HEADER_BYTE);
      end else begin
        n_lost++;
        rx_pos = 0;
        queue_item(1'b0, 8'h00, 1'b1, EV_LOST_HUNTING);
      end
      return;
    end
    link_now = LINK_RECEIVING;
    if (rx_pos >= 2 && rx_pos - 2 < ps) begin
      pay_store[rx_pos-2] = b;
      pay_written[rx_pos-2] = 1'b1;
      fold_sum(b);
    end else if (rx_pos == ps + 2) begin
      csum_lo_byte = b;
    end
    rx_pos++;
    if (rx_pos >= flen) begin
      rx_pos = 0;
      hdr_locked = 1'b0;
      if ({sum_hi, sum_lo} == {b, csum_lo_byte}) begin
        n_good++;
        for (int i = 0; i < ps; i++)
          queue_item(1'b1, pay_store[i], 1'b0, EV_FRAME_OK);
        queue_item(1'b0, 8'h00, 1'b1, EV_FRAME_OK);
      end else begin
        n_bad_csum++;
        queue_item(1'b0, 8'h00, 1'b1, EV_CHECKSUM_BAD);
      end
    end else begin
      queue_item(1'b0, 8'h00, 1'b1, EV_FRAME_BYTE);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Result stream checker
  always @(posedge clk) begin
    deframed_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (deframed_q.size() == 0) begin
        $error("item on result stream with nothing expected");
        fail_count++;
      end else begin
        want = deframed_q.pop_front();
        check_field("item_kind", 32'(want.kind), 32'(m_tuser));
        check_field("payload_byte", 32'(want.pay), 32'(m_tdata[7:0]));
        check_field("run_last", 32'(want.last), 32'(m_tlast));
        check_field("event_code", 32'(want.ev), 32'(m_tdata[10:8]));
        check_field("link_state", 32'(want.link), 32'(m_tdata[12:11]));
        check_field("bytes_seen", want.n_bytes, m_tdata[44:13]);
        check_field("frames_good", want.n_good, m_tdata[76:45]);
        check_field("checksum_failures", want.n_bad_csum, m_tdata[108:77]);
        check_field("sync_drops", want.n_drops, m_tdata[140:109]);
        check_field("bytes_lost_hunting", want.n_lost, m_tdata[172:141]);
      end
    end
  end

  // Result side back-pressure
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_steady = !rx_steady;
      gap = rx_steady ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    deframe_byte(b);
  endtask

  // Let every queued item come out, then give the block time to settle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (addr)
      ADDR_PAYLOAD_SIZE: cfg_ps = data[PS_W-1:0];
      ADDR_SYNC_FIRST:   cfg_sync1 = data[7:0];
      ADDR_SYNC_SECOND:  cfg_sync2 = data[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Complete whatever frame is open, or a whole new one, with a right or
  // deliberately broken checksum
  task automatic send_frame(input bit corrupt);
    logic [7:0] lo;
    logic [7:0] hi;
    if (rx_pos >= eff_of(cfg_ps) + 4) send_byte(8'($urandom_range(0, 255)));
    while (!hdr_locked) send_byte(rx_pos == 1 ? cfg_sync2 : cfg_sync1);
    while (rx_pos < eff_of(cfg_ps) + 2) send_byte(8'($urandom_range(0, 255)));
    lo = sum_lo;
    hi = sum_hi;
    if (corrupt) begin
      if ($urandom_range(0, 1) != 0) lo ^= 8'(1 << $urandom_range(0, 7));
      else hi ^= 8'(1 << $urandom_range(0, 7));
    end
    if (rx_pos == eff_of(cfg_ps) + 2) send_byte(lo);
    send_byte(hi);
  endtask

  // New settings for a phase; never grow the frame under a locked header
  // unless every store entry it would read has been written
  task automatic pick_config();
    logic [31:0] word;
    logic [PS_W-1:0] ps_new;
    logic [7:0] s1;
    case ($urandom_range(0, 9))
      0: ps_new = 6'd0;
      1: ps_new = 6'd63;
      2: ps_new = 6'd32;
      3: ps_new = 6'($urandom_range(9, 62));
      default: ps_new = 6'($urandom_range(1, 8));
    endcase
    if (!hdr_locked || eff_of(ps_new) <= eff_of(cfg_ps) || store_filled(eff_of(ps_new))) begin
      word = $urandom();
      word[PS_W-1:0] = ps_new;
      write_reg(ADDR_PAYLOAD_SIZE, word);
    end
    case ($urandom_range(0, 5))
      0: s1 = 8'h00;
      1: s1 = 8'hFF;
      default: s1 = 8'($urandom_range(0, 255));
    endcase
    if ($urandom_range(0, 3) != 0) begin
      word = $urandom();
      word[7:0] = s1;
      write_reg(ADDR_SYNC_FIRST, word);
    end
    if ($urandom_range(0, 3) != 0) begin
      word = $urandom();
      word[7:0] = ($urandom_range(0, 4) == 0) ? cfg_sync1 : 8'($urandom_range(0, 255));
      write_reg(ADDR_SYNC_SECOND, word);
    end
  endtask

  // Stimulus
  initial begin
    dir_row_t row;
    logic [31:0] random_from;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    drain_results();

    foreach (directed_rows[n]) begin
      row = directed_rows[n];
      case (row.kind)
        ROW_REG: begin
          drain_results();
          write_reg(row.addr, {24'd0, row.value});
        end
        ROW_CSUM_LO: send_byte(sum_lo);
        ROW_CSUM_HI: send_byte(sum_hi);
        default: send_byte(row.value);
      endcase
      if (row.fixed) begin
        deframed_q[deframed_q.size()-1].ev = row.ev;
        deframed_q[deframed_q.size()-1].link = row.link;
      end
    end

    // Random phases: mostly well-formed frames, some noise and broken ones
    random_from = n_bytes;
    while (n_bytes - random_from < RANDOM_BYTES) begin
      drain_results();
      pick_config();
      tx_steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 6)) begin
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
          1: begin
            send_byte(cfg_sync1);
            send_byte(($urandom_range(0, 1) != 0) ? cfg_sync1 : 8'($urandom_range(0, 255)));
          end
          2: send_frame(1'b1);
          3: begin
            // lower the frame length under an open frame
            while (!hdr_locked) send_byte(rx_pos == 1 ? cfg_sync2 : cfg_sync1);
            repeat ($urandom_range(3, 6)) send_byte(8'($urandom_range(0, 255)));
            drain_results();
            write_reg(ADDR_PAYLOAD_SIZE, 32'($urandom_range(0, 1)));
            send_byte(8'($urandom_range(0, 255)));
          end
          default: send_frame(1'b0);
        endcase
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
